// ===== rtl/hsa_pkg.sv =====
// Package for the HSL saturation adjust block: pixel word types, fixed-point
// widths, register map constants and the restoring divider step.
// No dependencies; imported by hsa_channel and hsl_saturation_adjust.
package hsa_pkg;

  localparam int CH_W    = 8;           // channel width
  localparam int SUM_W   = CH_W + 1;    // max + min
  localparam int FRAC_W  = 16;          // saturation fraction bits
  localparam int SAT_W   = FRAC_W + 1;  // saturation 0 .. 1.0 inclusive
  localparam int SNEW_W  = SAT_W + 2;   // signed sum of saturation and delta
  localparam int DELTA_W = 10;
  localparam int P1_W    = SAT_W + CH_W;     // new saturation times D
  localparam int BASE_W  = SUM_W + CH_W;     // sum times chroma
  localparam int DV_W    = SUM_W + 1;        // signed 2v - sum
  localparam int PROD_W  = DV_W + P1_W + 1;  // signed product
  localparam int NUM_W   = PROD_W + 2;       // signed numerator
  localparam int T_W     = NUM_W - 1 - (FRAC_W + 1);

  localparam int SDIV_STEPS  = 4;
  localparam int SDIV_STAGES = FRAC_W / SDIV_STEPS;
  localparam int CDIV_STEPS  = CH_W / 2;

  localparam int PIPE_LAST  = 12;
  localparam int CARRY_LAST = 11;

  localparam int APB_W     = 32;
  localparam int PADDR_W   = 3;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_DELTA = '0;

  localparam logic [CH_W-1:0]  MAXV    = {CH_W{1'b1}};
  localparam logic [SAT_W-1:0] SAT_ONE = {1'b1, {FRAC_W{1'b0}}};

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] blue_out;
  } pixel_out_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CH_W-1:0]   chroma;
    logic [P1_W-1:0]   p1;
    logic [BASE_W-1:0] base;
  } chan_ctl_t;

  // One restoring division step. The remainder is below the divisor on entry,
  // so it stays below it on exit. Returns {quotient bit, remainder}.
  function automatic logic [CH_W:0] div_step(input logic [CH_W-1:0] rem,
                                             input logic bit_in,
                                             input logic [CH_W-1:0] dvsr);
    logic [CH_W:0] trial;
    logic [CH_W:0] diff;
    trial = {rem, bit_in};
    diff  = trial - {1'b0, dvsr};
    if (trial >= {1'b0, dvsr}) begin
      div_step = {1'b1, diff[CH_W-1:0]};
    end else begin
      div_step = {1'b0, trial[CH_W-1:0]};
    end
  endfunction

endpackage

// ===== rtl/hsa_channel.sv =====
// One output channel of the saturation adjust: rebuilds the channel from
// lightness and new saturation, rounds, and divides by chroma. Four stages.
// Depends on hsa_pkg.
module hsa_channel
  import hsa_pkg::*;
(
  input  logic            clk,
  input  logic [CH_W-1:0] v,
  input  chan_ctl_t       ctl,
  output logic [CH_W-1:0] q
);

  // Stage A: signed product (2v - sum) * S' * D.
  logic signed [DV_W-1:0]   dv;
  logic signed [PROD_W-1:0] prod_a;
  logic [BASE_W-1:0]        base_a;
  logic [CH_W-1:0]          chroma_a;

  assign dv = $signed({1'b0, v, 1'b0}) - $signed({1'b0, ctl.sum});

  always_ff @(posedge clk) begin
    prod_a   <= $signed(dv) * $signed({1'b0, ctl.p1});
    base_a   <= ctl.base;
    chroma_a <= ctl.chroma;
  end

  // Stage B: numerator, floor at zero, add half the denominator, drop the
  // power-of-two part of the denominator.
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-2:0]        num_pos;
  logic [NUM_W-2:0]        num_rnd;
  logic [T_W-1:0]          t_b;
  logic [CH_W-1:0]         chroma_b;

  always_comb begin
    num = $signed({{(NUM_W-BASE_W-FRAC_W){1'b0}}, base_a, {FRAC_W{1'b0}}}) + prod_a;
    num_pos = num[NUM_W-1] ? '0 : num[NUM_W-2:0];
    num_rnd = num_pos + {{(NUM_W-1-CH_W-FRAC_W){1'b0}}, chroma_a, {FRAC_W{1'b0}}};
  end

  always_ff @(posedge clk) begin
    t_b      <= num_rnd[FRAC_W+1 +: T_W];
    chroma_b <= chroma_a;
  end

  // Stages C and D: quotient by chroma, half the bits in each stage.
  // A quotient that would not fit in a channel saturates to full scale.
  logic [CH_W-1:0] rem_c_next, quot_c_next, low_c_next;
  logic [CH_W-1:0] rem_c, quot_c, low_c, chroma_c;
  logic            sat_c;
  logic [CH_W-1:0] rem_d, quot_d, low_d;
  logic [CH_W:0]   st_c, st_d;

  always_comb begin
    rem_c_next  = t_b[CH_W +: CH_W];
    quot_c_next = '0;
    low_c_next  = t_b[CH_W-1:0];
    st_c        = '0;
    for (int k = 0; k < CDIV_STEPS; k++) begin
      st_c        = div_step(rem_c_next, low_c_next[CH_W-1], chroma_b);
      rem_c_next  = st_c[CH_W-1:0];
      quot_c_next = {quot_c_next[CH_W-2:0], st_c[CH_W]};
      low_c_next  = {low_c_next[CH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    sat_c    <= t_b[T_W-1:CH_W] >= {{(T_W-2*CH_W){1'b0}}, chroma_b};
    rem_c    <= rem_c_next;
    quot_c   <= quot_c_next;
    low_c    <= low_c_next;
    chroma_c <= chroma_b;
  end

  always_comb begin
    rem_d  = rem_c;
    quot_d = quot_c;
    low_d  = low_c;
    st_d   = '0;
    for (int k = 0; k < CH_W - CDIV_STEPS; k++) begin
      st_d   = div_step(rem_d, low_d[CH_W-1], chroma_c);
      rem_d  = st_d[CH_W-1:0];
      quot_d = {quot_d[CH_W-2:0], st_d[CH_W]};
      low_d  = {low_d[CH_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    q <= sat_c ? MAXV : quot_d;
  end

endmodule

// ===== rtl/hsl_saturation_adjust.sv =====
// An accepted word moves through the stage registers in order and shows on
// result with done, and is taken at the edge that ends the cycle of done.
// Throughput: one word per cycle through a 13-stage pipeline; busy stays low.
// The saturation divider (16 quotient bits, 4 per stage) sets the depth.
// Reset clears the valid pipeline, so words in flight are dropped, and sets
// sat_delta to 0.
module hsl_saturation_adjust
  import hsa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  pixel_in_t          pixel,
  output logic               done,
  output pixel_out_t         result,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_W-1:0]   pwdata,
  output logic [APB_W-1:0]   prdata,
  output logic               pready
);

  typedef struct packed {
    logic      gray;
    pixel_in_t pix;
  } carry_t;

  typedef struct packed {
    logic [SUM_W-1:0]  sum;
    logic [CH_W-1:0]   chroma;
    logic [CH_W-1:0]   d;
    logic [CH_W-1:0]   rem;
    logic [SAT_W-1:0]  quot;
    logic [FRAC_W-1:0] low;
  } sdiv_t;

  // Configuration register.
  logic signed [DELTA_W-1:0] sat_delta;
  logic [CFG_IDX_W-1:0]      cfg_idx;

  assign cfg_idx = paddr[2 +: CFG_IDX_W];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sat_delta <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_idx)
        REG_SAT_DELTA: sat_delta <= pwdata[DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_SAT_DELTA: prdata = {{(APB_W-DELTA_W){sat_delta[DELTA_W-1]}}, sat_delta};
      default:       prdata = '0;
    endcase
  end

  // Valid bits travel alongside the data.
  logic [PIPE_LAST:0] valid;

  assign busy = 1'b0;
  assign done = valid[PIPE_LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid <= {valid[PIPE_LAST-1:0], start};
    end
  end

  // Stage 0: input register.
  pixel_in_t pix0;

  always_ff @(posedge clk) begin
    pix0 <= pixel;
  end

  // Stage 1: max, min, sum, chroma and D.
  logic [CH_W-1:0]  mx, mn;
  logic [SUM_W-1:0] sum_next;
  logic [SUM_W-1:0] sum1;
  logic [CH_W-1:0]  chroma1, d1;
  carry_t           carry [1:CARRY_LAST];

  always_comb begin
    mx = pix0.red_in;
    mn = pix0.red_in;
    if (pix0.green_in > mx) mx = pix0.green_in;
    if (pix0.green_in < mn) mn = pix0.green_in;
    if (pix0.blue_in > mx) mx = pix0.blue_in;
    if (pix0.blue_in < mn) mn = pix0.blue_in;
    sum_next = {1'b0, mx} + {1'b0, mn};
  end

  always_ff @(posedge clk) begin
    sum1     <= sum_next;
    chroma1  <= mx - mn;
    d1       <= (sum_next > {1'b0, MAXV}) ? CH_W'({MAXV, 1'b0} - sum_next)
                                          : sum_next[CH_W-1:0];
    carry[1] <= '{gray: (mx == mn), pix: pix0};
    for (int i = 2; i <= CARRY_LAST; i++) begin
      carry[i] <= carry[i-1];
    end
  end

  // Stages 2 to 5: saturation S = (chroma * 2^16 + D/2) / D. The chroma part
  // is at most D, so its quotient is a single bit found up front.
  sdiv_t sdiv      [SDIV_STAGES];
  sdiv_t sdiv_next [SDIV_STAGES];

  always_comb begin
    sdiv_t         cur;
    logic [CH_W:0] st;
    st = '0;
    for (int s = 0; s < SDIV_STAGES; s++) begin
      if (s == 0) begin
        cur.sum    = sum1;
        cur.chroma = chroma1;
        cur.d      = d1;
        cur.quot   = SAT_W'(chroma1 == d1);
        cur.rem    = (chroma1 == d1) ? '0 : chroma1;
        cur.low    = FRAC_W'(d1 >> 1);
      end else begin
        cur = sdiv[s-1];
      end
      for (int k = 0; k < SDIV_STEPS; k++) begin
        st       = div_step(cur.rem, cur.low[FRAC_W-1], cur.d);
        cur.rem  = st[CH_W-1:0];
        cur.quot = {cur.quot[SAT_W-2:0], st[CH_W]};
        cur.low  = {cur.low[FRAC_W-2:0], 1'b0};
      end
      sdiv_next[s] = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SDIV_STAGES; s++) begin
      sdiv[s] <= sdiv_next[s];
    end
  end

  // Stage 6: add the delta and clamp the new saturation to [0, 1].
  logic signed [SNEW_W-1:0] ssum;
  logic [SAT_W-1:0]         snew6;
  logic [SUM_W-1:0]         sum6;
  logic [CH_W-1:0]          chroma6, d6;

  assign ssum = $signed({2'b00, sdiv[SDIV_STAGES-1].quot}) + $signed({sat_delta, 8'b0});

  always_ff @(posedge clk) begin
    if (ssum[SNEW_W-1]) begin
      snew6 <= '0;
    end else if (ssum > $signed({2'b00, SAT_ONE})) begin
      snew6 <= SAT_ONE;
    end else begin
      snew6 <= ssum[SAT_W-1:0];
    end
    sum6    <= sdiv[SDIV_STAGES-1].sum;
    chroma6 <= sdiv[SDIV_STAGES-1].chroma;
    d6      <= sdiv[SDIV_STAGES-1].d;
  end

  // Stage 7: products shared by the three channels.
  chan_ctl_t ctl7;

  always_ff @(posedge clk) begin
    ctl7.sum    <= sum6;
    ctl7.chroma <= chroma6;
    ctl7.p1     <= snew6 * d6;
    ctl7.base   <= sum6 * chroma6;
  end

  // Stages 8 to 11: per-channel rebuild.
  logic [CH_W-1:0] q_red, q_green, q_blue;

  hsa_channel u_red (
    .clk (clk),
    .v   (carry[7].pix.red_in),
    .ctl (ctl7),
    .q   (q_red)
  );

  hsa_channel u_green (
    .clk (clk),
    .v   (carry[7].pix.green_in),
    .ctl (ctl7),
    .q   (q_green)
  );

  hsa_channel u_blue (
    .clk (clk),
    .v   (carry[7].pix.blue_in),
    .ctl (ctl7),
    .q   (q_blue)
  );

  // Stage 12: output register. A gray word goes out unchanged.
  always_ff @(posedge clk) begin
    if (carry[CARRY_LAST].gray) begin
      result.red_out   <= carry[CARRY_LAST].pix.red_in;
      result.green_out <= carry[CARRY_LAST].pix.green_in;
      result.blue_out  <= carry[CARRY_LAST].pix.blue_in;
    end else begin
      result.red_out   <= q_red;
      result.green_out <= q_green;
      result.blue_out  <= q_blue;
    end
  end

endmodule

// ===== bench/tb_hsl_saturation_adjust.sv =====
// Self-checking bench for hsl_saturation_adjust: a directed table, then random pixels
// checked against an HSL saturation predictor, with sat_delta set over the APB port.
// Depends on hsa_pkg and the hsl_saturation_adjust RTL.
`timescale 1ns / 100ps

module tb_hsl_saturation_adjust;
  import hsa_pkg::*;

  localparam int     LATENCY   = 12;    // cycles from accept to done
  localparam int     WATCHDOG  = 2000;  // cycles with no progress before giving up
  localparam int     PHASES    = 7;
  localparam int     PER_PHASE = 200;
  localparam int     DIR_ROWS  = 32;
  localparam longint FULL      = (longint'(1) << CH_W) - 1;
  localparam longint ONE_Q16   = longint'(1) << FRAC_W;

  localparam logic [PADDR_W-1:0] ADDR_SAT_DELTA = {REG_SAT_DELTA, 2'b00};
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED  = {1'b1, 2'b00};

  typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [PADDR_W-1:0] addr;
    logic [APB_W-1:0]   data;
    pixel_in_t          px;
    logic               known;
    pixel_out_t         want;
  } dir_row_t;

  logic               clk     = 1'b0;
  logic               rst     = 1'b1;
  logic               start   = 1'b0;
  pixel_in_t          pixel   = '0;
  logic               psel    = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite  = 1'b0;
  logic [PADDR_W-1:0] paddr   = '0;
  logic [APB_W-1:0]   pwdata  = '0;
  logic               busy;
  logic               done;
  pixel_out_t         result;
  logic [APB_W-1:0]   prdata;
  logic               pready;

  logic [DELTA_W-1:0] sat_delta_model = '0;
  pixel_out_t         pixel_queue [$];
  logic               word_known = 1'b0;
  pixel_out_t         word_want  = '0;
  int                 errors     = 0;
  int                 stall_cycles = 0;
  dir_row_t           dir_table [DIR_ROWS];

  hsl_saturation_adjust u_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .pixel   (pixel),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #10 clk = ~clk;

  // Rebuild the pixel from its hue and lightness at the adjusted Q16 saturation.
  function automatic pixel_out_t adjust_pixel(input pixel_in_t px,
                                              input logic signed [DELTA_W-1:0] delta);
    longint     ch [3];
    longint     outv [3];
    longint     hi, lo, sum, chroma, span, sat, sat_new, den, num, v;
    pixel_out_t po;
    ch[0] = px.red_in;
    ch[1] = px.green_in;
    ch[2] = px.blue_in;
    hi = ch[0];
    lo = ch[0];
    for (int i = 1; i < 3; i++) begin
      if (ch[i] > hi) hi = ch[i];
      if (ch[i] < lo) lo = ch[i];
    end
    if (hi == lo) begin
      for (int i = 0; i < 3; i++) outv[i] = ch[i];
    end else begin
      sum     = hi + lo;
      chroma  = hi - lo;
      span    = (sum > FULL) ? (2 * FULL - sum) : sum;
      sat     = (chroma * ONE_Q16 + span / 2) / span;
      sat_new = sat + longint'(delta) * 256;
      if (sat_new < 0) sat_new = 0;
      if (sat_new > ONE_Q16) sat_new = ONE_Q16;
      den = 2 * chroma * ONE_Q16;
      for (int i = 0; i < 3; i++) begin
        num = sum * chroma * ONE_Q16 + (2 * ch[i] - sum) * sat_new * span;
        if (num < 0) num = 0;
        v = (num + den / 2) / den;
        if (v > FULL) v = FULL;
        outv[i] = v;
      end
    end
    po.red_out   = outv[0][CH_W-1:0];
    po.green_out = outv[1][CH_W-1:0];
    po.blue_out  = outv[2][CH_W-1:0];
    return po;
  endfunction

  function automatic dir_row_t word_row(input int r, input int g, input int b);
    dir_row_t row;
    row       = '0;
    row.kind  = ROW_WORD;
    row.px    = '{r[CH_W-1:0], g[CH_W-1:0], b[CH_W-1:0]};
    return row;
  endfunction

  function automatic dir_row_t known_row(input int r, input int g, input int b,
                                         input int er, input int eg, input int eb);
    dir_row_t row;
    row       = word_row(r, g, b);
    row.known = 1'b1;
    row.want  = '{er[CH_W-1:0], eg[CH_W-1:0], eb[CH_W-1:0]};
    return row;
  endfunction

  function automatic dir_row_t cfg_row(input logic [PADDR_W-1:0] addr,
                                       input logic [APB_W-1:0] data);
    dir_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.addr = addr;
    row.data = data;
    return row;
  endfunction

  function automatic pixel_in_t rand_pixel();
    logic [CH_W-1:0] corners [4];
    pixel_in_t       p;
    int              pick;
    corners = '{8'd0, 8'd1, 8'd254, 8'd255};
    p    = pixel_in_t'($urandom);
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        p.green_in = p.red_in;
        p.blue_in  = p.red_in;
      end
      1: begin
        p.red_in   = corners[$urandom_range(0, 3)];
        p.green_in = corners[$urandom_range(0, 3)];
        p.blue_in  = corners[$urandom_range(0, 3)];
      end
      2: begin
        // Nearly gray: tiny chroma stresses the division rounding.
        p.green_in = p.red_in ^ CH_W'($urandom_range(0, 3));
        p.blue_in  = p.red_in ^ CH_W'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return p;
  endfunction

  // Called just after a falling edge; returns just after the falling edge that
  // follows the accepting rising edge, with start still high.
  task automatic put_word(input pixel_in_t px, input logic known, input pixel_out_t want);
    word_known = known;
    word_want  = want;
    start <= 1'b1;
    pixel <= px;
    while (busy) @(negedge clk);
    @(negedge clk);
  endtask

  task automatic idle_for(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pixel_queue.size() != 0) @(negedge clk);
  endtask

  task automatic apb_transfer(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [APB_W-1:0] data, output logic [APB_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    rdata = prdata;
    if (wr && addr == ADDR_SAT_DELTA) sat_delta_model = data[DELTA_W-1:0];
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
  endtask

  // Write a register, then read sat_delta back to confirm what the block holds.
  task automatic set_register(input logic [PADDR_W-1:0] addr, input logic [APB_W-1:0] data);
    logic [APB_W-1:0] rd;
    apb_transfer(1'b1, addr, data, rd);
    apb_transfer(1'b0, ADDR_SAT_DELTA, '0, rd);
    if (rd[DELTA_W-1:0] !== sat_delta_model) begin
      $error("sat_delta: expected %0h, actual %0h", sat_delta_model, rd[DELTA_W-1:0]);
      errors++;
    end
  endtask

  always @(posedge clk) begin : monitor
    pixel_out_t want;
    logic       moved;
    if (!rst) begin
      moved = 1'b0;
      if (done) begin
        moved = 1'b1;
        if (pixel_queue.size() == 0) begin
          $error("result word with no pixel outstanding");
          errors++;
        end else begin
          want = pixel_queue.pop_front();
          if (result.red_out !== want.red_out) begin
            $error("red_out: expected %0d, actual %0d", want.red_out, result.red_out);
            errors++;
          end
          if (result.green_out !== want.green_out) begin
            $error("green_out: expected %0d, actual %0d", want.green_out, result.green_out);
            errors++;
          end
          if (result.blue_out !== want.blue_out) begin
            $error("blue_out: expected %0d, actual %0d", want.blue_out, result.blue_out);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        moved = 1'b1;
        pixel_queue.push_back(word_known ? word_want : adjust_pixel(pixel, sat_delta_model));
      end
      if (psel && penable && pready) moved = 1'b1;
      stall_cycles = moved ? 0 : stall_cycles + 1;
      if (stall_cycles >= WATCHDOG) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial begin
    logic [DELTA_W-1:0] raw;
    logic [APB_W-1:0]   junk;
    dir_table = '{
      known_row(0, 0, 0, 0, 0, 0),
      known_row(255, 255, 255, 255, 255, 255),
      known_row(128, 128, 128, 128, 128, 128),
      known_row(255, 0, 0, 255, 0, 0),
      known_row(0, 255, 0, 0, 255, 0),
      known_row(0, 0, 255, 0, 0, 255),
      known_row(1, 0, 0, 1, 0, 0),
      word_row(255, 254, 254),
      word_row(200, 100, 100),
      // A write to an unmapped register must leave sat_delta at zero.
      cfg_row(ADDR_UNMAPPED, 32'h0000_0100),
      known_row(255, 0, 0, 255, 0, 0),
      cfg_row(ADDR_SAT_DELTA, 32'hFFFF_FF00),
      known_row(255, 0, 0, 128, 128, 128),
      known_row(10, 0, 0, 5, 5, 5),
      known_row(100, 50, 51, 75, 75, 75),
      known_row(77, 77, 77, 77, 77, 77),
      cfg_row(ADDR_SAT_DELTA, 32'h0000_0100),
      word_row(200, 100, 100),
      word_row(255, 0, 128),
      word_row(1, 2, 3),
      cfg_row(ADDR_SAT_DELTA, 32'h0000_01FF),
      word_row(30, 60, 90),
      word_row(250, 251, 252),
      cfg_row(ADDR_SAT_DELTA, 32'h0000_0200),
      known_row(255, 0, 0, 128, 128, 128),
      word_row(3, 200, 17),
      // Upper data bits carry junk; only the low ten bits count.
      cfg_row(ADDR_SAT_DELTA, 32'hABCD_0025),
      word_row(12, 34, 56),
      word_row(240, 16, 128),
      word_row(254, 255, 254),
      cfg_row(ADDR_SAT_DELTA, 32'h0000_03FF),
      word_row(90, 180, 45)
    };

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_table[i].kind == ROW_CFG) begin
        drain();
        set_register(dir_table[i].addr, dir_table[i].data);
      end else begin
        put_word(dir_table[i].px, dir_table[i].known, dir_table[i].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      case (ph)
        0: raw = 10'h100;
        1: raw = 10'h300;
        2: raw = 10'h1FF;
        3: raw = 10'h200;
        default: raw = DELTA_W'($urandom_range(0, 1023));
      endcase
      if ($urandom_range(0, 1) == 0) set_register(ADDR_UNMAPPED, $urandom);
      junk = $urandom;
      set_register(ADDR_SAT_DELTA, {junk[APB_W-1:DELTA_W], raw});
      for (int n = 0; n < PER_PHASE; n++) begin
        if (ph == 3 && n == PER_PHASE / 2) drain();
        // The final phase runs back to back with no gaps.
        if (ph < PHASES - 1 && $urandom_range(0, 7) == 0) idle_for($urandom_range(1, 6));
        put_word(rand_pixel(), 1'b0, '0);
      end
    end

    drain();
    repeat (LATENCY + 8) @(negedge clk);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== hsl_saturation_adjust.f =====
rtl/hsa_pkg.sv
rtl/hsa_channel.sv
rtl/hsl_saturation_adjust.sv
bench/tb_hsl_saturation_adjust.sv
